@@ hdl/sbpf_pkg.sv @@
// Shared types and constants of the servo bus packet framer.
package sbpf_pkg;

   localparam logic [7:0] HEADER_BYTE       = 8'hFF;
   localparam logic [7:0] BROADCAST_ID      = 8'hFE;
   localparam logic [7:0] NORMAL_LEN_OFFSET = 8'd3;
   localparam logic [7:0] SYNC_LEN_OFFSET   = 8'd4;
   localparam logic [7:0] SYNC_OPCODE_RESET = 8'd131;
   localparam int         FRAME_BYTES       = 8;
   localparam int         SLOT_BITS         = $clog2(FRAME_BYTES);

   typedef enum logic [1:0] {
      CMD_NORMAL   = 2'd0,
      CMD_SYNC     = 2'd1,
      CMD_SERVO_ID = 2'd2,
      CMD_PAYLOAD  = 2'd3
   } command_type;

   typedef struct packed {
      command_type command;
      logic [7:0]  servo_id;
      logic [7:0]  instruction;
      logic [7:0]  start_address;
      logic [7:0]  data_length;
      logic [7:0]  servo_count;
      logic [7:0]  data_byte;
      logic        final_item;
   } request_type;

   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] bytes;
      logic [SLOT_BITS-1:0]        last;
   } frame_type;

   typedef struct packed {
      logic ready;
      logic busy;
   } ser_status_type;

endpackage

@@ hdl/sbpf_build.sv @@
// Byte builder: turns one request into its output bytes and the next running sum.
module sbpf_build (
   input  sbpf_pkg::request_type req,
   input  logic [7:0]            sum,
   input  logic [7:0]            sync_opcode,
   output sbpf_pkg::frame_type   frame,
   output logic [7:0]            sum_next
);

   logic [15:0]                   prod;
   logic [7:0]                    len;
   logic [7:0]                    total;
   logic [sbpf_pkg::SLOT_BITS-1:0] count;

   always_comb begin
      prod        = 16'(req.data_length) * 16'(req.servo_count);
      len         = 8'h00;
      total       = 8'h00;
      count       = '0;
      frame.bytes = '0;
      frame.last  = '0;
      case (req.command)
         sbpf_pkg::CMD_NORMAL: begin
            len            = req.data_length + sbpf_pkg::NORMAL_LEN_OFFSET;
            frame.bytes[0] = sbpf_pkg::HEADER_BYTE;
            frame.bytes[1] = sbpf_pkg::HEADER_BYTE;
            frame.bytes[2] = req.servo_id;
            frame.bytes[3] = len;
            frame.bytes[4] = req.instruction;
            frame.bytes[5] = req.start_address;
            total          = req.servo_id + len + req.instruction + req.start_address;
            count          = sbpf_pkg::SLOT_BITS'(6);
         end
         sbpf_pkg::CMD_SYNC: begin
            len            = prod[7:0] + req.servo_count + sbpf_pkg::SYNC_LEN_OFFSET;
            frame.bytes[0] = sbpf_pkg::HEADER_BYTE;
            frame.bytes[1] = sbpf_pkg::HEADER_BYTE;
            frame.bytes[2] = sbpf_pkg::BROADCAST_ID;
            frame.bytes[3] = len;
            frame.bytes[4] = sync_opcode;
            frame.bytes[5] = req.start_address;
            frame.bytes[6] = req.data_length;
            total          = sbpf_pkg::BROADCAST_ID + len + sync_opcode
                           + req.start_address + req.data_length;
            count          = sbpf_pkg::SLOT_BITS'(7);
         end
         sbpf_pkg::CMD_SERVO_ID: begin
            frame.bytes[0] = req.servo_id;
            total          = sum + req.servo_id;
            count          = sbpf_pkg::SLOT_BITS'(1);
         end
         default: begin
            frame.bytes[0] = req.data_byte;
            total          = sum + req.data_byte;
            count          = sbpf_pkg::SLOT_BITS'(1);
         end
      endcase
      if (req.final_item) begin
         frame.bytes[count] = ~total;
         frame.last         = count;
         sum_next           = 8'h00;
      end else begin
         frame.last = count - sbpf_pkg::SLOT_BITS'(1);
         sum_next   = total;
      end
   end

endmodule

@@ hdl/sbpf_serializer.sv @@
// Output serializer: holds one built frame and sends its bytes one at a time, each held until the output takes it.
module sbpf_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sbpf_pkg::frame_type   frame,
   output sbpf_pkg::ser_status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_end_of_run
);

   logic                            valid_ff;
   logic                            valid_in;
   logic [sbpf_pkg::SLOT_BITS-1:0]  idx_ff;
   logic [sbpf_pkg::SLOT_BITS-1:0]  idx_in;
   sbpf_pkg::frame_type             frame_ff;
   sbpf_pkg::frame_type             frame_in;
   logic                            take;
   logic                            done;

   always_comb begin
      take           = valid_ff && !rsp_stall;
      done           = take && (idx_ff == frame_ff.last);
      status.ready   = !valid_ff || done;
      status.busy    = valid_ff;
      rsp_valid      = valid_ff;
      rsp_tx_byte    = frame_ff.bytes[idx_ff];
      rsp_end_of_run = (idx_ff == frame_ff.last);
      valid_in       = valid_ff;
      idx_in         = idx_ff;
      frame_in       = frame_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
         frame_in = frame;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + sbpf_pkg::SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      frame_ff <= frame_in;
   end

endmodule

@@ hdl/servo_bus_packet_framer_unit.sv @@
// Top level of the servo bus packet framer: request register, builder, serializer.
// A request waits in the request register, and its first byte is offered once the
// serializer has loaded the built frame into its own frame register.
// Throughput: one output byte per cycle while rsp_stall is low; a request emits
// one or two bytes for body requests, six to eight for start requests.
// The single request register frees as the serializer loads, so requests stream.
// Reset (synchronous) empties both stages, clears the running sum, opcode to 131.
module servo_bus_packet_framer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_servo_id,
   input  logic [7:0] req_instruction,
   input  logic [7:0] req_start_address,
   input  logic [7:0] req_data_length,
   input  logic [7:0] req_servo_count,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_end_of_run,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic                     req_valid_ff;
   logic                     req_valid_in;
   sbpf_pkg::request_type    req_ff;
   sbpf_pkg::request_type    req_in;
   logic [7:0]               sum_ff;
   logic [7:0]               sum_in;
   logic [7:0]               sum_next;
   logic [7:0]               opcode_ff;
   logic [7:0]               opcode_in;
   logic                     accept;
   logic                     load;
   sbpf_pkg::frame_type      frame;
   sbpf_pkg::ser_status_type ser_status;

   always_comb begin
      load      = req_valid_ff && ser_status.ready;
      req_stall = req_valid_ff && !ser_status.ready;
      accept    = req_valid && !req_stall;
      req_in    = req_ff;
      if (accept) begin
         req_in.command       = sbpf_pkg::command_type'(req_command);
         req_in.servo_id      = req_servo_id;
         req_in.instruction   = req_instruction;
         req_in.start_address = req_start_address;
         req_in.data_length   = req_data_length;
         req_in.servo_count   = req_servo_count;
         req_in.data_byte     = req_data_byte;
         req_in.final_item    = req_final_item;
      end
      req_valid_in = accept ? 1'b1 : (load ? 1'b0 : req_valid_ff);
      sum_in       = load ? sum_next : sum_ff;
      opcode_in    = csr_write_enable ? csr_write_data : opcode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         sum_ff       <= 8'h00;
         opcode_ff    <= sbpf_pkg::SYNC_OPCODE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         sum_ff       <= sum_in;
         opcode_ff    <= opcode_in;
      end
      req_ff <= req_in;
   end

   sbpf_build u_build (
      .req         (req_ff),
      .sum         (sum_ff),
      .sync_opcode (opcode_ff),
      .frame       (frame),
      .sum_next    (sum_next)
   );

   sbpf_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .frame          (frame),
      .status         (ser_status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_end_of_run (rsp_end_of_run)
   );

   a_sum_clears: assert property (@(posedge clock) disable iff (reset)
      load && req_ff.final_item |=> sum_ff == 8'h00)
      else $error("running sum not cleared after checksum");

   a_start_header: assert property (@(posedge clock) disable iff (reset)
      load && (req_ff.command == sbpf_pkg::CMD_NORMAL || req_ff.command == sbpf_pkg::CMD_SYNC)
      |=> rsp_valid && rsp_tx_byte == sbpf_pkg::HEADER_BYTE)
      else $error("frame start does not begin with header byte");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && ser_status.busy)
      else $error("request stalled with no pending work");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_run && !rsp_stall && !load |=> !rsp_valid)
      else $error("output continues past end of run");

endmodule
